FILE: design/haes_pkg.sv
// shared types and constants for the health-aware endpoint selector
package haes_pkg;

  localparam int unsigned MaxEndpoints = 32;
  localparam int unsigned IdxW         = 5;
  localparam int unsigned CntW         = 6;
  localparam int unsigned LatW         = 24;
  localparam int unsigned CostW        = 32;

  localparam logic [1:0] H_UNKNOWN   = 2'd0;
  localparam logic [1:0] H_HEALTHY   = 2'd1;
  localparam logic [1:0] H_UNHEALTHY = 2'd2;

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_REPORT = 3'd1;
  localparam logic [2:0] MODE_SELECT = 3'd2;
  localparam logic [2:0] MODE_MARK_H = 3'd3;
  localparam logic [2:0] MODE_MARK_U = 3'd4;
  localparam logic [2:0] MODE_RESET  = 3'd5;

  localparam logic [1:0] STRAT_LAT   = 2'd0;
  localparam logic [1:0] STRAT_COST  = 2'd1;
  localparam logic [1:0] STRAT_RR    = 2'd2;
  localparam logic [1:0] STRAT_FIRST = 2'd3;

  localparam logic [1:0] CFG_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_LIMIT    = 2'd1;

  typedef struct packed {
    logic [2:0]       mode;
    logic [IdxW-1:0]  endpoint_index;
    logic             success;
    logic [LatW-1:0]  lat_sample;
    logic [CostW-1:0] cost;
  } req_t;

  typedef struct packed {
    logic            accepted;
    logic            chosen_valid;
    logic [IdxW-1:0] chosen_index;
    logic            went_unhealthy;
    logic            recovered;
    logic [CntW-1:0] healthy_count;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch request
    logic rd;          // read entry at scan index, round-robin pointer or addressed index
    logic scan_eval;   // evaluate entry read last cycle
    logic wr_upd;      // write back addressed entry
    logic wr_clr;      // clear entry last read
    logic finish;      // drive result
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       addressed;
    logic       scan_last;
    logic       found;      // round robin / first found a candidate
    logic       empty;
  } sts_t;

endpackage

FILE: design/haes_datapath.sv
// endpoint table, scan unit and result register
module haes_datapath import haes_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  req_t                req_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output res_t                res_o,
  output logic                res_valid_o
);

  // simple dual-port style table: one read (registered) and one write per cycle
  logic [1:0]       hs_mem   [MaxEndpoints];
  logic [7:0]       run_mem  [MaxEndpoints];
  logic [LatW-1:0]  lat_mem  [MaxEndpoints];
  logic [CostW-1:0] cost_mem [MaxEndpoints];

  req_t            req_q;
  logic [1:0]      strat_q;
  logic [7:0]      limit_q;
  logic [CntW-1:0] used_q, used_d;
  logic [IdxW-1:0] rot_q, rot_d;
  logic [CntW-1:0] hcnt_q, hcnt_d;
  logic [IdxW-1:0] scan_q, scan_d;
  logic [IdxW-1:0] rd_idx_q;
  logic [1:0]       rd_hs_q;
  logic [7:0]       rd_run_q;
  logic [LatW-1:0]  rd_lat_q;
  logic [CostW-1:0] rd_cost_q;
  logic             best_v_q, best_v_d;
  logic [IdxW-1:0]  best_i_q, best_i_d;
  logic [1:0]       best_hs_q, best_hs_d;
  logic [LatW-1:0]  best_lat_q, best_lat_d;
  logic [CostW-1:0] best_cost_q, best_cost_d;
  res_t             res_q, res_d;
  logic             rv_q;

  logic [IdxW-1:0] addr;
  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_addr;
  logic            full;
  logic            add_we;
  logic            wr_en;
  logic [1:0]      wr_hs;
  logic [7:0]      wr_run;
  logic [LatW-1:0] wr_lat;
  logic            wu, rec;
  logic [7:0]      run_inc, lim_eff;
  logic [LatW+2:0] mean_sum;
  logic            sel, better;
  logic [CntW-1:0] scan_ext;
  logic [IdxW-1:0] rot_mod;

  assign addr     = req_q.endpoint_index;
  assign scan_ext = {1'b0, scan_q};
  assign full     = used_q == CntW'(MaxEndpoints);
  assign add_we   = cmd_i.capture && req_i.mode == MODE_ADD && !full;
  // pointer is always below used except after shrink, which never happens
  assign rot_mod  = ({1'b0, rot_q} < used_q) ? rot_q : '0;
  // round robin walks the pointer itself, which advances on every evaluated entry
  assign rd_addr  = (req_q.mode == MODE_SELECT && strat_q == STRAT_RR) ? rot_mod
                    : ((req_q.mode == MODE_SELECT || req_q.mode == MODE_RESET) ? scan_q : addr);
  assign wr_addr  = add_we ? used_q[IdxW-1:0] : rd_idx_q;

  assign sts_o.mode      = req_q.mode;
  assign sts_o.addressed = {1'b0, addr} < used_q;
  assign sts_o.scan_last = scan_ext + 1'b1 >= used_q;
  assign sts_o.empty     = used_q == '0;
  assign sel             = rd_hs_q != H_UNHEALTHY;
  assign sts_o.found     = sel && (strat_q == STRAT_RR || strat_q == STRAT_FIRST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_idx_q  <= rd_addr;
      rd_hs_q   <= hs_mem[rd_addr];
      rd_run_q  <= run_mem[rd_addr];
      rd_lat_q  <= lat_mem[rd_addr];
      rd_cost_q <= cost_mem[rd_addr];
    end
    if (wr_en) begin
      hs_mem[wr_addr]  <= wr_hs;
      run_mem[wr_addr] <= wr_run;
      lat_mem[wr_addr] <= wr_lat;
    end
    if (add_we)
      cost_mem[used_q[IdxW-1:0]] <= req_i.cost;
  end

  assign run_inc  = (rd_run_q == 8'hFF) ? rd_run_q : rd_run_q + 8'd1;
  assign lim_eff  = (limit_q == '0) ? 8'd1 : limit_q;
  assign mean_sum = {3'b0, rd_lat_q} * 3'd7 + {3'b0, req_q.lat_sample};

  always_comb begin
    wr_en  = 1'b0;
    wr_hs  = rd_hs_q;
    wr_run = rd_run_q;
    wr_lat = rd_lat_q;
    wu     = 1'b0;
    rec    = 1'b0;
    if (add_we) begin
      // new entry starts unknown with no history
      wr_en = 1'b1; wr_hs = H_UNKNOWN; wr_run = '0; wr_lat = '0;
    end else if (cmd_i.wr_clr) begin
      wr_en = 1'b1; wr_hs = H_UNKNOWN; wr_run = '0; wr_lat = '0;
    end else if (cmd_i.wr_upd) begin
      wr_en = 1'b1;
      case (req_q.mode)
        MODE_REPORT: begin
          if (req_q.success) begin
            wr_run = '0;
            wr_lat = (rd_lat_q == '0) ? req_q.lat_sample : mean_sum[LatW+2:3];
            wr_hs  = H_HEALTHY;
            rec    = rd_hs_q == H_UNHEALTHY;
          end else begin
            wr_run = run_inc;
            if (run_inc >= lim_eff) begin
              wr_hs = H_UNHEALTHY;
              wu    = rd_hs_q != H_UNHEALTHY;
            end
          end
        end
        MODE_MARK_H: begin
          rec = rd_hs_q == H_UNHEALTHY; wr_hs = H_HEALTHY; wr_run = '0;
        end
        MODE_MARK_U: begin
          wu = rd_hs_q != H_UNHEALTHY; wr_hs = H_UNHEALTHY;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_comb begin
    better = 1'b0;
    if (!best_v_q) better = 1'b1;
    else if (strat_q == STRAT_LAT)
      better = rd_lat_q < best_lat_q || (rd_lat_q == best_lat_q &&
               rd_hs_q == H_HEALTHY && best_hs_q != H_HEALTHY);
    else
      better = rd_cost_q < best_cost_q || (rd_cost_q == best_cost_q &&
               rd_lat_q < best_lat_q);
  end

  always_comb begin
    used_d      = used_q;
    rot_d       = rot_q;
    scan_d      = scan_q;
    hcnt_d      = hcnt_q;
    best_v_d    = best_v_q;
    best_i_d    = best_i_q;
    best_hs_d   = best_hs_q;
    best_lat_d  = best_lat_q;
    best_cost_d = best_cost_q;
    res_d       = res_q;
    if (cmd_i.capture) begin
      scan_d   = '0;
      best_v_d = 1'b0;
      res_d    = '0;
      if (add_we) begin
        used_d             = used_q + 1'b1;
        res_d.accepted     = 1'b1;
        res_d.chosen_index = used_q[IdxW-1:0];
      end
    end
    if (cmd_i.rd) scan_d = scan_q + 1'b1;
    if (cmd_i.scan_eval) begin
      if (strat_q == STRAT_RR)
        rot_d = (CntW'(rd_idx_q) + 1'b1 >= used_q) ? '0 : rd_idx_q + 1'b1;
      if (sel && better) begin
        best_v_d = 1'b1; best_i_d = rd_idx_q; best_hs_d = rd_hs_q;
        best_lat_d = rd_lat_q; best_cost_d = rd_cost_q;
      end
    end
    if (cmd_i.wr_upd && wr_en) begin
      res_d.accepted = 1'b1;
      res_d.went_unhealthy = wu;
      res_d.recovered = rec;
      if (rd_hs_q == H_HEALTHY && wr_hs != H_HEALTHY) hcnt_d = hcnt_q - 1'b1;
      if (rd_hs_q != H_HEALTHY && wr_hs == H_HEALTHY) hcnt_d = hcnt_q + 1'b1;
    end
    if (cmd_i.wr_clr) begin
      hcnt_d = '0;
      rot_d  = '0;
    end
    if (cmd_i.finish) begin
      if (req_q.mode == MODE_SELECT) begin
        res_d.accepted     = 1'b1;
        res_d.chosen_valid = best_v_d;
        res_d.chosen_index = best_v_d ? best_i_d : '0;
      end
      if (req_q.mode == MODE_RESET) begin
        res_d.accepted = 1'b1; rot_d = '0; hcnt_d = '0;
      end
      res_d.healthy_count = hcnt_d;
    end
    if (cfg_we_i && cfg_idx_i == CFG_STRATEGY) rot_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strat_q  <= STRAT_LAT;
      limit_q  <= 8'd3;
      used_q   <= '0;
      rot_q    <= '0;
      hcnt_q   <= '0;
      scan_q   <= '0;
      best_v_q <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_STRATEGY) strat_q <= cfg_data_i[1:0];
      if (cfg_we_i && cfg_idx_i == CFG_LIMIT)    limit_q <= cfg_data_i;
      used_q   <= used_d;
      rot_q    <= rot_d;
      hcnt_q   <= hcnt_d;
      scan_q   <= scan_d;
      best_v_q <= best_v_d;
      rv_q     <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
    best_i_q    <= best_i_d;
    best_hs_q   <= best_hs_d;
    best_lat_q  <= best_lat_d;
    best_cost_q <= best_cost_d;
    res_q       <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = rv_q;

endmodule

FILE: design/haes_ctrl.sv
// sequencer for the endpoint table operations
module haes_ctrl import haes_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    last_d  = last_q;
    case (state_q)
      S_IDLE: if (start_i) begin
        cmd_o.capture = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        case (sts_i.mode)
          MODE_SELECT, MODE_RESET: begin
            if (sts_i.empty) state_d = S_DONE;
            else begin
              cmd_o.rd = 1'b1;
              last_d   = sts_i.scan_last;
              state_d  = (sts_i.mode == MODE_SELECT) ? S_EVAL : S_CLR;
            end
          end
          MODE_REPORT, MODE_MARK_H, MODE_MARK_U: begin
            if (sts_i.addressed) begin
              cmd_o.rd = 1'b1; state_d = S_UPD;
            end else state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        last_d   = sts_i.scan_last;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.scan_eval = 1'b1;
        state_d = (last_q || sts_i.found) ? S_DONE : S_SCAN;
      end
      S_UPD: begin
        cmd_o.wr_upd = 1'b1; state_d = S_DONE;
      end
      S_CLR: begin
        // clear entry read last cycle and, unless it was the last, fetch the next
        cmd_o.wr_clr = 1'b1;
        if (last_q) state_d = S_DONE;
        else begin
          cmd_o.rd = 1'b1;
          last_d   = sts_i.scan_last;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  assign busy_o = state_q != S_IDLE;

endmodule

FILE: design/health_aware_endpoint_selector.sv
// Endpoint selector: a request is taken when start is high and busy is low. Add, requests for
// an index not in use and unused modes pass through decode and done; report and the marks add
// an update state. Select scans the table through a registered read, with alternating read
// and evaluate states per entry, and stops early when round robin or first selectable finds a
// candidate; reset stats clears one entry per cycle. Either on an empty table goes straight
// from decode to done. The result shows on res_o for one cycle with res_valid_o, in the cycle
// that busy falls, and cannot be stalled. Configuration writes are always ready, unknown
// register indexes are ignored, and writes should be made while idle.
module health_aware_endpoint_selector import haes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output res_t       res_o,
  output logic       res_valid_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i;

  haes_ctrl u_ctrl (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .sts_i (sts), .cmd_o (cmd), .busy_o (busy)
  );

  haes_datapath u_dp (
    .clk_i (clk_i), .rst_ni (rst_ni), .req_i (req_i),
    .cfg_we_i (cfg_we), .cfg_idx_i (cfg_index_i), .cfg_data_i (cfg_data_i),
    .cmd_i (cmd), .sts_o (sts), .res_o (res_o), .res_valid_o (res_valid_o)
  );

endmodule
